// ===== src/uer_pkg.sv =====
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

    localparam int TRIG_W     = 8;
    localparam int TMO_W      = 20;
    localparam int DIST_W     = 11;
    localparam int BAR_W      = 8;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 20;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;

    localparam logic [TRIG_W-1:0] TRIG_RESET = 8'd10;
    localparam logic [TMO_W-1:0]  TMO_RESET  = 20'd56000;
    localparam logic [TMO_W-1:0]  TMO_MAX    = 20'hFFFFF;
    localparam logic [DIST_W-1:0] DIST_MAX   = 11'd2047;

    // distance_cm = floor(width * CM_NUM / CM_DEN), i.e. width / 58.82
    localparam int CM_NUM      = 50;
    localparam int CM_DEN      = 2941;
    localparam int BAR_STEP_CM = 20;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TRIGGER_TICKS,
        CFG_TIMEOUT_TICKS
    } t_cfg_addr;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIG,
        PH_WAIT,
        PH_MEAS
    } t_phase;

    typedef struct packed {
        logic trig;
        logic done;
        logic err;
    } t_flags;

    localparam int FLAGS_W = $bits(t_flags);

endpackage

// ===== src/uer_front.sv =====
// Front end: per-tick trigger / echo-wait / echo-measure sequencer.
module uer_front #(
    parameter int PULSE_COUNT_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_start,
    input  logic                        i_echo,
    input  logic [uer_pkg::TRIG_W-1:0]  i_trigger_ticks,
    input  logic [uer_pkg::TMO_W-1:0]   i_timeout_ticks,
    input  logic                        i_full,
    output logic                        o_push,
    output uer_pkg::t_flags             o_flags,
    output logic [PULSE_COUNT_BITS-1:0] o_width
);
    import uer_pkg::*;

    localparam logic [PULSE_COUNT_BITS-1:0] PULSE_MAX = '1;

    t_phase                      r_phase, n_phase;
    logic [TRIG_W-1:0]           r_trig_cnt, n_trig_cnt;
    logic [TMO_W-1:0]            r_tmo_cnt, n_tmo_cnt;
    logic [PULSE_COUNT_BITS-1:0] r_pulse_width, n_pulse_width;
    logic [TMO_W-1:0]            tmo_inc;
    logic                        accept;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;
    assign tmo_inc = (r_tmo_cnt < TMO_MAX) ? r_tmo_cnt + 1'b1 : r_tmo_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_trig_cnt    <= '0;
            r_tmo_cnt     <= '0;
            r_pulse_width <= '0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_trig_cnt    <= n_trig_cnt;
            r_tmo_cnt     <= n_tmo_cnt;
            r_pulse_width <= n_pulse_width;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_trig_cnt    = r_trig_cnt;
        n_tmo_cnt     = r_tmo_cnt;
        n_pulse_width = r_pulse_width;
        o_flags       = '0;
        o_width       = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_start) begin
                    n_phase      = PH_TRIG;
                    n_trig_cnt   = TRIG_W'(1);
                    o_flags.trig = 1'b1;
                end
            end
            PH_TRIG: begin
                if (r_trig_cnt < i_trigger_ticks) begin
                    n_trig_cnt   = r_trig_cnt + 1'b1;
                    o_flags.trig = 1'b1;
                end else begin
                    n_phase   = PH_WAIT;
                    n_tmo_cnt = '0;
                end
            end
            PH_WAIT: begin
                n_tmo_cnt = tmo_inc;
                if (i_echo) begin
                    n_phase       = PH_MEAS;
                    n_pulse_width = PULSE_COUNT_BITS'(1);
                end else if (tmo_inc >= i_timeout_ticks) begin
                    n_phase      = PH_IDLE;
                    o_flags.done = 1'b1;
                    o_flags.err  = 1'b1;
                end
            end
            PH_MEAS: begin
                n_tmo_cnt = tmo_inc;
                if (!i_echo) begin
                    n_phase      = PH_IDLE;
                    o_flags.done = 1'b1;
                    o_width      = r_pulse_width;
                end else begin
                    if (r_pulse_width < PULSE_MAX) begin
                        n_pulse_width = r_pulse_width + 1'b1;
                    end
                    if (tmo_inc >= i_timeout_ticks) begin
                        n_phase      = PH_IDLE;
                        o_flags.done = 1'b1;
                        o_flags.err  = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

endmodule

// ===== src/uer_queue.sv =====
// Small register FIFO between the sequencer and the distance pipeline.
module uer_queue #(
    parameter int DATA_W = 19,
    parameter int DEPTH  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output logic [DATA_W-1:0] o_data
);
    import uer_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [PTR_W:0]    r_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == (PTR_W+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== src/uer_back.sv =====
// Back end: pulse width to centimeters and LED bar, three-stage pipeline.
module uer_back #(
    parameter int PULSE_COUNT_BITS = 16,
    parameter int LED_COUNT        = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_empty,
    output logic                        o_pop,
    input  uer_pkg::t_flags             i_flags,
    input  logic [PULSE_COUNT_BITS-1:0] i_width,
    output logic                        o_valid,
    input  logic                        i_ready,
    output uer_pkg::t_flags             o_flags,
    output logic [uer_pkg::DIST_W-1:0]  o_dist,
    output logic [uer_pkg::BAR_W-1:0]   o_bar
);
    import uer_pkg::*;

    // Reciprocal scaling: floor(w*RECIP >> K) equals floor(w*50/2941) for all w
    localparam int K      = PULSE_COUNT_BITS + 12;
    localparam int MW     = PULSE_COUNT_BITS + 7;
    localparam int PW     = PULSE_COUNT_BITS + MW;
    localparam int QW     = PW - K;
    localparam int EXT_W  = (QW > DIST_W) ? QW : DIST_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'(CM_NUM) << K) + 64'(CM_DEN - 1)) / 64'(CM_DEN);
    localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];
    localparam logic [DIST_W-1:0] FAR_CM = DIST_W'((LED_COUNT + 1) * BAR_STEP_CM);

    logic              advance;
    logic              r_v1, r_v2, r_v3;
    t_flags            r_f1, r_f2, r_f3;
    logic [PW-1:0]     r_prod;
    logic [DIST_W-1:0] r_dist2, r_dist3;
    logic [BAR_W-1:0]  r_bar3;
    logic [EXT_W-1:0]  quot_ext;
    logic [DIST_W-1:0] dist_sat;
    logic [BAR_W-1:0]  bar_raw;
    logic              good;

    assign advance = !r_v3 || i_ready;
    assign o_pop   = advance && !i_empty;

    assign quot_ext = EXT_W'(r_prod[PW-1:K]);
    assign dist_sat = (quot_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(quot_ext);

    always_comb begin
        for (int i = 0; i < BAR_W; i++) begin
            bar_raw[i] = (r_dist2 >= DIST_W'((i + 1) * BAR_STEP_CM));
        end
    end

    assign good = r_f2.done && !r_f2.err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (advance) begin
            r_v1 <= !i_empty;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_f1    <= i_flags;
            r_prod  <= PW'(i_width) * PW'(RECIP);
            r_f2    <= r_f1;
            r_dist2 <= dist_sat;
            r_f3    <= r_f2;
            // drop distance and bar unless a clean echo finished
            r_dist3 <= good ? r_dist2 : '0;
            r_bar3  <= (good && (r_dist2 < FAR_CM)) ? bar_raw : '0;
        end
    end

    assign o_valid = r_v3;
    assign o_flags = r_f3;
    assign o_dist  = r_dist3;
    assign o_bar   = r_bar3;

endmodule

// ===== src/ultrasonic_echo_ranger.sv =====
// Top level of the ultrasonic echo ranger.
// Each input beat is one 1 us timebase tick carrying a start request (bit 0)
// and the sampled echo level (bit 1); every accepted tick yields exactly one
// output beat, in order. A start while idle raises the trigger for
// trigger_ticks ticks (the start tick counts as the first), then the block
// waits for echo, counts the high ticks (saturating) and, on echo fall,
// reports done with distance_cm = floor(width*50/2941) and a thermometer bar
// of distance/20 (zero when beyond LED_COUNT levels). A timeout counted from
// the end of the trigger gives done with timed_out set and zero distance.
// Starts during a measurement are ignored. One tick is taken every clock
// cycle; the sequencer resolves a tick in the cycle it is accepted, and the
// result leaves through a four-entry queue and a three-stage pipeline
// (reciprocal multiply, scale and saturate, bar). The input is held off
// only when output back-pressure has filled the queue.
// Configuration writes take effect at the next edge and should be made idle.
module ultrasonic_echo_ranger #(
    parameter int PULSE_COUNT_BITS = 16,
    parameter int LED_COUNT        = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [0] start_req, [1] echo, [7:2] zero
    input  logic [uer_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [0] trigger_level, [1] done_res, [2] timed_out, [13:3] distance_cm,
    // [21:14] bar_pattern, [23:22] zero
    output logic [uer_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [uer_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [uer_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import uer_pkg::*;

    localparam int EVT_W = FLAGS_W + PULSE_COUNT_BITS;

    logic [TRIG_W-1:0]           r_trigger_ticks;
    logic [TMO_W-1:0]            r_timeout_ticks;

    logic                        q_full, q_empty, q_push, q_pop;
    t_flags                      front_flags, head_flags, out_flags;
    logic [PULSE_COUNT_BITS-1:0] front_width, head_width;
    logic [EVT_W-1:0]            q_head;
    logic [DIST_W-1:0]           out_dist;
    logic [BAR_W-1:0]            out_bar;

    // Configuration registers; writes beyond the list are ignored by decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trigger_ticks <= TRIG_RESET;
            r_timeout_ticks <= TMO_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_TRIGGER_TICKS: r_trigger_ticks <= i_cfg_wdata[TRIG_W-1:0];
                CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_wdata[TMO_W-1:0];
                default:           r_trigger_ticks <= r_trigger_ticks;
            endcase
        end
    end

    // Sequencer: classify each tick and emit one event per tick
    uer_front #(
        .PULSE_COUNT_BITS (PULSE_COUNT_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_s_axis_tvalid),
        .o_ready         (o_s_axis_tready),
        .i_start         (i_s_axis_tdata[0]),
        .i_echo          (i_s_axis_tdata[1]),
        .i_trigger_ticks (r_trigger_ticks),
        .i_timeout_ticks (r_timeout_ticks),
        .i_full          (q_full),
        .o_push          (q_push),
        .o_flags         (front_flags),
        .o_width         (front_width)
    );

    // Decouple the sequencer from output back-pressure
    uer_queue #(
        .DATA_W (EVT_W),
        .DEPTH  (4)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  ({front_flags, front_width}),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_head)
    );

    assign head_flags = t_flags'(q_head[EVT_W-1:PULSE_COUNT_BITS]);
    assign head_width = q_head[PULSE_COUNT_BITS-1:0];

    // Distance and bar computation, holds its last stage as the output register
    uer_back #(
        .PULSE_COUNT_BITS (PULSE_COUNT_BITS),
        .LED_COUNT        (LED_COUNT)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .i_flags (head_flags),
        .i_width (head_width),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_flags (out_flags),
        .o_dist  (out_dist),
        .o_bar   (out_bar)
    );

    assign o_m_axis_tdata = {2'b00, out_bar, out_dist,
                             out_flags.err, out_flags.done, out_flags.trig};

endmodule
